@@ design/trpd_pkg.sv @@
// Shared types and constants for the TGA run-length pixel decoder.
// Used by every module of the decoder and by its checker.
package trpd_pkg;

   // Parse phases of the decoder.
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HEADER = 3'd1,
      PH_SKIP   = 3'd2,
      PH_PACKET = 3'd3,
      PH_PIXEL  = 3'd4
   } phase_type;

   // Result kinds.
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_SPAN   = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Header error codes.
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_TYPE     = 2'd1;
   localparam logic [1:0] ERR_COLORMAP = 2'd2;
   localparam logic [1:0] ERR_DEPTH    = 2'd3;

   // Header byte positions.
   localparam logic [4:0] HDR_POS_ID_LEN    = 5'd0;
   localparam logic [4:0] HDR_POS_CMAP_TYPE = 5'd1;
   localparam logic [4:0] HDR_POS_IMG_TYPE  = 5'd2;
   localparam logic [4:0] HDR_POS_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_POS_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_POS_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_POS_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_POS_DEPTH     = 5'd16;
   localparam logic [4:0] HDR_POS_LAST      = 5'd17;

   // Header field values.
   localparam logic [7:0] IMG_TYPE_RAW = 8'd2;
   localparam logic [7:0] IMG_TYPE_RLE = 8'd10;
   localparam logic [7:0] DEPTH_24     = 8'd24;
   localparam logic [7:0] DEPTH_32     = 8'd32;
   localparam logic [6:0] RUN_LEN_MASK = 7'h7F;

   // Channel positions inside one pixel (file order is B, G, R, A).
   localparam logic [1:0] CH_BLUE  = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_RED   = 2'd2;
   localparam logic [1:0] CH_ALPHA = 2'd3;

   // One input item.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_file;
   } in_item_type;

   // One result item.
   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  error_code;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [31:0] pixel_index;
      logic [7:0]  run_count;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        image_done;
   } result_type;

endpackage

@@ design/tga_rle_pixel_decoder.sv @@
// TGA true-color decoder taking one file byte per item and producing header,
// error and RGBA pixel-span items. Each byte passes an input register and a
// single decode stage into a result register, so one byte is accepted every
// cycle while the result side keeps taking items. A result is decoded from the
// input register into the result register and offered from there.
// The decode stage holds the parse state;
// its longest path is the 16 by 16 multiply that forms the pixel total on the
// last header byte. Raw images give one span per pixel; run packets give one
// span with a run count clipped at the image end. The alpha setting should be
// written only while no bytes are in flight. Depends on trpd_pkg.
module tga_rle_pixel_decoder import trpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Byte input channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_new_file,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_error_code,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [31:0] rsp_pixel_index,
   output logic [7:0]  rsp_run_count,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic        rsp_image_done,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_invert_alpha
);

   in_item_type req_item;
   in_item_type item;
   logic        item_valid;
   logic        slot_free;
   logic        fire;
   logic        res_valid;
   result_type  core_res;
   result_type  out_res;
   logic        invert_alpha_ff;

   assign req_item.data_byte = req_data_byte;
   assign req_item.new_file  = req_new_file;

   // An item is decoded when the result slot can take what it produces.
   assign fire = item_valid && slot_free;

   // Configuration register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         invert_alpha_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         invert_alpha_ff <= csr_invert_alpha;
      end
   end

   trpd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .pop        (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   trpd_core u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .item         (item),
      .invert_alpha (invert_alpha_ff),
      .res_valid    (res_valid),
      .res          (core_res)
   );

   trpd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && res_valid),
      .load_res  (core_res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .slot_free (slot_free),
      .res       (out_res)
   );

   assign rsp_kind         = out_res.kind;
   assign rsp_error_code   = out_res.error_code;
   assign rsp_red          = out_res.red;
   assign rsp_green        = out_res.green;
   assign rsp_blue         = out_res.blue;
   assign rsp_alpha        = out_res.alpha;
   assign rsp_pixel_index  = out_res.pixel_index;
   assign rsp_run_count    = out_res.run_count;
   assign rsp_image_width  = out_res.image_width;
   assign rsp_image_height = out_res.image_height;
   assign rsp_image_done   = out_res.image_done;

endmodule

@@ design/trpd_in_reg.sv @@
// Input register of the decoder: holds one accepted byte item until the
// decode stage takes it. Depends on trpd_pkg for the item type.
module trpd_in_reg import trpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  in_item_type req_item,
   input  logic        pop,
   output logic        item_valid,
   output in_item_type item
);

   logic        valid_ff;
   logic        valid_in;
   in_item_type item_ff;

   // A new item may enter when the register is empty or drains this cycle.
   assign req_ready = !valid_ff || pop;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ design/trpd_core.sv @@
// Decode stage: header parse, id skip, packet and pixel decode, one byte per
// fire. Holds all parse state. Depends on trpd_pkg.
module trpd_core import trpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  in_item_type item,
   input  logic        invert_alpha,
   output logic        res_valid,
   output result_type  res
);

   phase_type   phase_ff, phase_in;
   logic [4:0]  header_count_ff, header_count_in;
   logic [7:0]  id_skip_left_ff, id_skip_left_in;
   logic        is_compressed_ff, is_compressed_in;
   logic        has_alpha_ff, has_alpha_in;
   logic [15:0] width_reg_ff, width_reg_in;
   logic [15:0] height_reg_ff, height_reg_in;
   logic [31:0] pixels_left_ff, pixels_left_in;
   logic [31:0] pixels_done_ff, pixels_done_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic        packet_is_run_ff, packet_is_run_in;
   logic [1:0]  channel_pos_ff, channel_pos_in;
   logic [23:0] color_gather_ff, color_gather_in;
   logic [1:0]  hdr_fault_ff, hdr_fault_in;

   logic [7:0]  b;
   logic        hdr_last;
   logic        hdr_empty;
   logic        enter_data_hdr;
   logic        skip_end;
   logic        pix_finish;
   logic [23:0] color_next;
   logic        run_span;
   logic        left_short;
   logic [7:0]  span_cnt;
   logic        span_done;
   logic [7:0]  packet_left_fin;
   logic [7:0]  alpha_val;
   logic [31:0] pixel_area;

   assign b = item.data_byte;

   // Shared decode terms.
   assign hdr_last       = (phase_ff == PH_HEADER) && (header_count_ff == HDR_POS_LAST);
   assign hdr_empty      = (width_reg_ff == 16'd0) || (height_reg_ff == 16'd0);
   assign enter_data_hdr = hdr_last && (hdr_fault_ff == ERR_NONE) && !hdr_empty
                           && (id_skip_left_ff == 8'd0);
   assign skip_end       = (id_skip_left_ff <= 8'd1);
   assign pixel_area     = 32'(width_reg_ff) * 32'(height_reg_ff);

   // Gather the current byte into its color lane.
   always_comb begin
      color_next = color_gather_ff;
      case (channel_pos_ff)
         CH_BLUE:  color_next[7:0]   = b;
         CH_GREEN: color_next[15:8]  = b;
         CH_RED:   color_next[23:16] = b;
         default:  color_next = color_gather_ff;
      endcase
   end

   // A pixel finishes on its last color byte, or on the alpha byte.
   assign pix_finish = (phase_ff == PH_PIXEL) &&
                       ((channel_pos_ff == CH_ALPHA) ||
                        ((channel_pos_ff == CH_RED) && !has_alpha_ff));
   assign alpha_val  = (channel_pos_ff == CH_ALPHA) ? (invert_alpha ? b : ~b) : 8'hFF;

   // Span length: a run packet is clipped at the pixels still owed.
   assign run_span   = is_compressed_ff && packet_is_run_ff;
   assign left_short = (pixels_left_ff[31:8] == 24'd0) &&
                       (pixels_left_ff[7:0] < packet_left_ff);
   assign span_cnt   = !run_span ? 8'd1 :
                       (left_short ? pixels_left_ff[7:0] : packet_left_ff);
   assign span_done  = (pixels_left_ff[31:8] == 24'd0) && (pixels_left_ff[7:0] == span_cnt);

   always_comb begin
      if (run_span) begin
         packet_left_fin = 8'd0;
      end else if (is_compressed_ff && (packet_left_ff != 8'd0)) begin
         packet_left_fin = packet_left_ff - 8'd1;
      end else begin
         packet_left_fin = packet_left_ff;
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (item.new_file) begin
         phase_in = PH_HEADER;
      end else begin
         case (phase_ff)
            PH_HEADER: begin
               if (hdr_last) begin
                  if ((hdr_fault_ff != ERR_NONE) || hdr_empty) begin
                     phase_in = PH_IDLE;
                  end else if (id_skip_left_ff != 8'd0) begin
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = is_compressed_ff ? PH_PACKET : PH_PIXEL;
                  end
               end
            end
            PH_SKIP: begin
               if (skip_end) begin
                  phase_in = is_compressed_ff ? PH_PACKET : PH_PIXEL;
               end
            end
            PH_PACKET: phase_in = PH_PIXEL;
            PH_PIXEL: begin
               if (pix_finish) begin
                  if (span_done) begin
                     phase_in = PH_IDLE;
                  end else if (is_compressed_ff && (packet_left_fin == 8'd0)) begin
                     phase_in = PH_PACKET;
                  end
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // Result of the current byte.
   always_comb begin
      res       = '0;
      res_valid = 1'b0;
      if (!item.new_file) begin
         if (hdr_last) begin
            res_valid = 1'b1;
            if (hdr_fault_ff != ERR_NONE) begin
               res.kind       = KIND_ERROR;
               res.error_code = hdr_fault_ff;
            end else begin
               res.kind         = KIND_HEADER;
               res.image_width  = width_reg_ff;
               res.image_height = height_reg_ff;
               res.image_done   = hdr_empty;
            end
         end else if (pix_finish) begin
            res_valid       = 1'b1;
            res.kind        = KIND_SPAN;
            res.red         = color_next[23:16];
            res.green       = color_next[15:8];
            res.blue        = color_next[7:0];
            res.alpha       = alpha_val;
            res.pixel_index = pixels_done_ff;
            res.run_count   = span_cnt;
            res.image_done  = span_done;
         end
      end
   end

   // Next values of the parse state.
   always_comb begin
      header_count_in  = header_count_ff;
      id_skip_left_in  = id_skip_left_ff;
      is_compressed_in = is_compressed_ff;
      has_alpha_in     = has_alpha_ff;
      width_reg_in     = width_reg_ff;
      height_reg_in    = height_reg_ff;
      pixels_left_in   = pixels_left_ff;
      pixels_done_in   = pixels_done_ff;
      packet_left_in   = packet_left_ff;
      packet_is_run_in = packet_is_run_ff;
      channel_pos_in   = channel_pos_ff;
      color_gather_in  = color_gather_ff;
      hdr_fault_in     = hdr_fault_ff;
      if (item.new_file) begin
         // Restart: this byte is header byte zero, the id field length.
         header_count_in  = 5'd1;
         id_skip_left_in  = b;
         is_compressed_in = 1'b0;
         has_alpha_in     = 1'b0;
         width_reg_in     = 16'd0;
         height_reg_in    = 16'd0;
         pixels_left_in   = 32'd0;
         pixels_done_in   = 32'd0;
         packet_left_in   = 8'd0;
         packet_is_run_in = 1'b0;
         channel_pos_in   = CH_BLUE;
         color_gather_in  = 24'd0;
         hdr_fault_in     = ERR_NONE;
      end else begin
         case (phase_ff)
            PH_HEADER: begin
               header_count_in = header_count_ff + 5'd1;
               case (header_count_ff)
                  HDR_POS_ID_LEN: id_skip_left_in = b;
                  HDR_POS_CMAP_TYPE: begin
                     if (b != 8'd0) begin
                        hdr_fault_in = ERR_COLORMAP;
                     end
                  end
                  HDR_POS_IMG_TYPE: begin
                     if (!(b inside {IMG_TYPE_RAW, IMG_TYPE_RLE})) begin
                        hdr_fault_in = ERR_TYPE;
                     end
                     is_compressed_in = (b == IMG_TYPE_RLE);
                  end
                  HDR_POS_WIDTH_LO:  width_reg_in[7:0]   = b;
                  HDR_POS_WIDTH_HI:  width_reg_in[15:8]  = b;
                  HDR_POS_HEIGHT_LO: height_reg_in[7:0]  = b;
                  HDR_POS_HEIGHT_HI: height_reg_in[15:8] = b;
                  HDR_POS_DEPTH: begin
                     if ((hdr_fault_ff == ERR_NONE) && !(b inside {DEPTH_24, DEPTH_32})) begin
                        hdr_fault_in = ERR_DEPTH;
                     end
                     has_alpha_in = (b == DEPTH_32);
                  end
                  HDR_POS_LAST: begin
                     pixels_left_in = pixel_area;
                     pixels_done_in = 32'd0;
                  end
                  default: header_count_in = header_count_ff + 5'd1;
               endcase
               if (enter_data_hdr) begin
                  channel_pos_in   = CH_BLUE;
                  color_gather_in  = 24'd0;
                  packet_left_in   = 8'd0;
                  packet_is_run_in = 1'b0;
               end
            end
            PH_SKIP: begin
               if (id_skip_left_ff != 8'd0) begin
                  id_skip_left_in = id_skip_left_ff - 8'd1;
               end
               if (skip_end) begin
                  channel_pos_in   = CH_BLUE;
                  color_gather_in  = 24'd0;
                  packet_left_in   = 8'd0;
                  packet_is_run_in = 1'b0;
               end
            end
            PH_PACKET: begin
               packet_is_run_in = b[7];
               packet_left_in   = {1'b0, b[6:0] & RUN_LEN_MASK} + 8'd1;
               channel_pos_in   = CH_BLUE;
               color_gather_in  = 24'd0;
            end
            PH_PIXEL: begin
               if (pix_finish) begin
                  packet_left_in  = packet_left_fin;
                  pixels_done_in  = pixels_done_ff + 32'(span_cnt);
                  pixels_left_in  = pixels_left_ff - 32'(span_cnt);
                  channel_pos_in  = CH_BLUE;
                  color_gather_in = 24'd0;
               end else begin
                  channel_pos_in  = channel_pos_ff + 2'd1;
                  color_gather_in = color_next;
               end
            end
            default: header_count_in = header_count_ff;
         endcase
      end
   end

   // Parse state registers, updated once per processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         header_count_ff  <= 5'd0;
         id_skip_left_ff  <= 8'd0;
         is_compressed_ff <= 1'b0;
         has_alpha_ff     <= 1'b0;
         width_reg_ff     <= 16'd0;
         height_reg_ff    <= 16'd0;
         pixels_left_ff   <= 32'd0;
         pixels_done_ff   <= 32'd0;
         packet_left_ff   <= 8'd0;
         packet_is_run_ff <= 1'b0;
         channel_pos_ff   <= CH_BLUE;
         color_gather_ff  <= 24'd0;
         hdr_fault_ff     <= ERR_NONE;
      end else if (fire) begin
         phase_ff         <= phase_in;
         header_count_ff  <= header_count_in;
         id_skip_left_ff  <= id_skip_left_in;
         is_compressed_ff <= is_compressed_in;
         has_alpha_ff     <= has_alpha_in;
         width_reg_ff     <= width_reg_in;
         height_reg_ff    <= height_reg_in;
         pixels_left_ff   <= pixels_left_in;
         pixels_done_ff   <= pixels_done_in;
         packet_left_ff   <= packet_left_in;
         packet_is_run_ff <= packet_is_run_in;
         channel_pos_ff   <= channel_pos_in;
         color_gather_ff  <= color_gather_in;
         hdr_fault_ff     <= hdr_fault_in;
      end
   end

endmodule

@@ design/trpd_out_reg.sv @@
// Result register of the decoder: holds one result item until the
// consumer takes it. Depends on trpd_pkg for the result type.
module trpd_out_reg import trpd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_res,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output logic       slot_free,
   output result_type res
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   // The slot frees up when empty or when the held item is taken now.
   assign slot_free = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= load_res;
      end
   end

   assign rsp_valid = valid_ff;
   assign res       = res_ff;

endmodule

@@ design/trpd_checker.sv @@
// Port-level checks for the TGA decoder result channel, bound to the top
// level. Depends on trpd_pkg for result kinds and error codes.
module trpd_checker import trpd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [1:0]  rsp_error_code,
   input logic [7:0]  rsp_run_count,
   input logic [31:0] rsp_pixel_index,
   input logic [15:0] rsp_image_width,
   input logic [15:0] rsp_image_height,
   input logic        rsp_image_done
);

   // A stalled result item holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_pixel_index) && $stable(rsp_run_count))
      else $error("stalled result item changed");

   // The result register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item present after reset");

   // A span always covers at least one pixel and carries no error.
   a_span_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_SPAN |->
      rsp_run_count != 8'd0 && rsp_error_code == ERR_NONE)
      else $error("malformed span item");

   // A header item flags the image done exactly when it is empty.
   a_header_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_HEADER |->
      rsp_image_done == (rsp_image_width == 16'd0 || rsp_image_height == 16'd0))
      else $error("header done flag does not match dimensions");

   // An error item names a fault.
   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |->
      rsp_error_code != ERR_NONE && !rsp_image_done)
      else $error("error item without a fault code");

endmodule

bind tga_rle_pixel_decoder trpd_checker u_trpd_checker (.*);

@@ dv/tga_rle_pixel_decoder_tb.sv @@
// Self-checking testbench for tga_rle_pixel_decoder: TGA byte streams in, predicted
// header, error and RGBA span items compared against the result channel.
// Depends on trpd_pkg and the tga_rle_pixel_decoder RTL.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_tb;
   import trpd_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BYTES = 500;
   localparam int WHOLE_FILE   = 32'h7FFF_FFFF;
   localparam int SETTLE       = 8;

   // How run-length packets are laid out when a file is built.
   typedef enum {PKT_MIXED, PKT_LONG_RUNS, PKT_LONG_RAW} packet_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_new_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [1:0]  rsp_error_code;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic [31:0] rsp_pixel_index;
   logic [7:0]  rsp_run_count;
   logic [15:0] rsp_image_width;
   logic [15:0] rsp_image_height;
   logic        rsp_image_done;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_invert_alpha = 1'b0;

   // Stimulus bookkeeping.
   in_item_type tga_bytes[$];
   result_type  predicted_records[$];
   int          bytes_queued = 0;
   int          bytes_accepted = 0;
   int          file_bytes = 0;
   int          body_left = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   int          fail_count = 0;
   logic        pace_gaps = 1'b1;
   logic        pace_stalls = 1'b1;

   // Predictor state, mirroring the decoder's parse state.
   logic        cfg_invert = 1'b0;
   phase_type   dec_phase = PH_IDLE;
   logic [4:0]  hdr_pos = '0;
   logic [7:0]  id_left = '0;
   logic        rle = 1'b0;
   logic        alpha_present = 1'b0;
   logic [15:0] img_w = '0;
   logic [15:0] img_h = '0;
   logic [31:0] px_total = '0;
   logic [31:0] px_done = '0;
   logic [7:0]  pkt_left = '0;
   logic        pkt_run = 1'b0;
   logic [1:0]  chan = '0;
   logic [23:0] color = '0;
   logic [1:0]  fault = ERR_NONE;

   tga_rle_pixel_decoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_new_file     (req_new_file),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_error_code   (rsp_error_code),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_pixel_index  (rsp_pixel_index),
      .rsp_run_count    (rsp_run_count),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_image_done   (rsp_image_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_invert_alpha (csr_invert_alpha)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Enter pixel data: packet headers for run-length files, pixels for raw ones.
   function void start_pixels();
      chan = CH_BLUE;
      color = '0;
      pkt_left = '0;
      pkt_run = 1'b0;
      dec_phase = rle ? PH_PACKET : PH_PIXEL;
   endfunction

   // Close one gathered pixel into a span, clipping runs at the image end.
   function void finish_span(input logic [7:0] a);
      logic [31:0] cnt;
      logic [31:0] remaining;
      logic        done;
      result_type  r;
      cnt = 32'd1;
      r = '0;
      r.pixel_index = px_done;
      if (rle && pkt_run) begin
         remaining = px_total - px_done;
         cnt = 32'(pkt_left);
         if (cnt > remaining) cnt = remaining;
         pkt_left = '0;
      end else if (rle && pkt_left != 0) begin
         pkt_left = pkt_left - 8'd1;
      end
      px_done = px_done + cnt;
      done = (px_done == px_total);
      r.kind = KIND_SPAN;
      r.red = color[23:16];
      r.green = color[15:8];
      r.blue = color[7:0];
      r.alpha = a;
      r.run_count = cnt[7:0];
      r.image_done = done;
      predicted_records.push_back(r);
      chan = CH_BLUE;
      color = '0;
      if (done) dec_phase = PH_IDLE;
      else if (rle && pkt_left == 0) dec_phase = PH_PACKET;
   endfunction

   // Advance the decoder prediction by one accepted byte.
   function void decode_byte(input logic [7:0] b, input logic nf);
      logic       last;
      result_type r;
      if (nf) begin
         dec_phase = PH_HEADER;
         hdr_pos = '0;
         id_left = '0;
         rle = 1'b0;
         alpha_present = 1'b0;
         img_w = '0;
         img_h = '0;
         px_total = '0;
         px_done = '0;
         pkt_left = '0;
         pkt_run = 1'b0;
         chan = CH_BLUE;
         color = '0;
         fault = ERR_NONE;
      end
      case (dec_phase)
         PH_HEADER: begin
            case (hdr_pos)
               HDR_POS_ID_LEN:    id_left = b;
               HDR_POS_CMAP_TYPE: if (b != 8'd0) fault = ERR_COLORMAP;
               HDR_POS_IMG_TYPE: begin
                  if (b != IMG_TYPE_RLE && b != IMG_TYPE_RAW) fault = ERR_TYPE;
                  rle = (b == IMG_TYPE_RLE);
               end
               HDR_POS_WIDTH_LO:  img_w[7:0] = b;
               HDR_POS_WIDTH_HI:  img_w[15:8] = b;
               HDR_POS_HEIGHT_LO: img_h[7:0] = b;
               HDR_POS_HEIGHT_HI: img_h[15:8] = b;
               HDR_POS_DEPTH: begin
                  if (fault == ERR_NONE && b != DEPTH_32 && b != DEPTH_24) fault = ERR_DEPTH;
                  alpha_present = (b == DEPTH_32);
               end
               default: ;
            endcase
            last = (hdr_pos == HDR_POS_LAST);
            hdr_pos = hdr_pos + 5'd1;
            if (last) begin
               r = '0;
               if (fault != ERR_NONE) begin
                  r.kind = KIND_ERROR;
                  r.error_code = fault;
                  dec_phase = PH_IDLE;
               end else begin
                  px_total = 32'(img_w) * 32'(img_h);
                  px_done = '0;
                  r.kind = KIND_HEADER;
                  r.image_width = img_w;
                  r.image_height = img_h;
                  if (px_total == 0) begin
                     r.image_done = 1'b1;
                     dec_phase = PH_IDLE;
                  end else if (id_left != 0) begin
                     dec_phase = PH_SKIP;
                  end else begin
                     start_pixels();
                  end
               end
               predicted_records.push_back(r);
            end
         end
         PH_SKIP: begin
            if (id_left != 0) id_left = id_left - 8'd1;
            if (id_left == 0) start_pixels();
         end
         PH_PACKET: begin
            pkt_run = b[7];
            pkt_left = {1'b0, b[6:0] & RUN_LEN_MASK} + 8'd1;
            chan = CH_BLUE;
            color = '0;
            dec_phase = PH_PIXEL;
         end
         PH_PIXEL: begin
            if (chan != CH_ALPHA) begin
               color[8*chan +: 8] = b;
               chan = chan + 2'd1;
               if (chan == CH_ALPHA && !alpha_present) finish_span(8'hFF);
            end else begin
               finish_span(cfg_invert ? b : ~b);
            end
         end
         default: ;
      endcase
   endfunction

   function string describe(input result_type r);
      return $sformatf({"kind=%0d err=%0d rgba=%02h%02h%02h%02h idx=%0d run=%0d",
                        " w=%0d h=%0d done=%0d"},
                       r.kind, r.error_code, r.red, r.green, r.blue, r.alpha,
                       r.pixel_index, r.run_count, r.image_width, r.image_height,
                       r.image_done);
   endfunction

   // Compare one received item with the oldest prediction.
   task check_result(input result_type got);
      result_type want;
      if (predicted_records.size() == 0) begin
         fail_count++;
         if (fail_count <= 10) $display("result with no prediction: %s", describe(got));
      end else begin
         want = predicted_records.pop_front();
         if (got.kind !== want.kind || got.error_code !== want.error_code ||
             got.red !== want.red || got.green !== want.green ||
             got.blue !== want.blue || got.alpha !== want.alpha ||
             got.pixel_index !== want.pixel_index || got.run_count !== want.run_count ||
             got.image_width !== want.image_width ||
             got.image_height !== want.image_height ||
             got.image_done !== want.image_done) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("mismatch: expected %s", describe(want));
               $display("          actual   %s", describe(got));
            end
         end
      end
   endtask

   // Byte driver: one item from the pending queue at a time, with random gaps when paced.
   always @(posedge clock) begin : byte_driver
      in_item_type next_item;
      logic        launch;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            decode_byte(req_data_byte, req_new_file);
            bytes_accepted++;
         end
         if (!req_valid || req_ready) begin
            launch = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (tga_bytes.size() > 0) begin
               next_item = tga_bytes.pop_front();
               req_data_byte <= next_item.data_byte;
               req_new_file <= next_item.new_file;
               launch = 1'b1;
               gap_left = pace_gaps ? $urandom_range(0, 6) : 0;
            end
            req_valid <= launch;
         end
      end
   end

   // Result monitor: checks each accepted item, then may stall ready at random when paced.
   always @(posedge clock) begin : result_monitor
      result_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.kind = rsp_kind;
            got.error_code = rsp_error_code;
            got.red = rsp_red;
            got.green = rsp_green;
            got.blue = rsp_blue;
            got.alpha = rsp_alpha;
            got.pixel_index = rsp_pixel_index;
            got.run_count = rsp_run_count;
            got.image_width = rsp_image_width;
            got.image_height = rsp_image_height;
            got.image_done = rsp_image_done;
            check_result(got);
            stall_left = pace_stalls ? $urandom_range(0, 6) : 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task push_item(input logic [7:0] b, input logic nf);
      tga_bytes.push_back('{data_byte: b, new_file: nf});
      bytes_queued++;
   endtask

   // Bytes after the header stop once the file's byte budget runs out.
   task push_body(input logic [7:0] b);
      if (body_left > 0) begin
         push_item(b, 1'b0);
         body_left--;
      end
   endtask

   function logic [7:0] pick_byte(input int fill);
      return (fill < 0) ? 8'($urandom) : 8'(fill);
   endfunction

   // Build one file: header, id field, then raw pixels or run-length packets.
   task emit_file(input logic [7:0] img_type, input logic [7:0] cmap_type,
                  input logic [7:0] depth, input logic [15:0] w, input logic [15:0] h,
                  input logic [7:0] id_len, input int fill, input packet_style_type style,
                  input int budget);
      logic [7:0]  hb;
      logic [31:0] total;
      logic [31:0] remaining;
      int          len;
      int          bpp;
      logic        run;
      for (int pos = 0; pos < 18; pos++) begin
         case (5'(pos))
            HDR_POS_ID_LEN:    hb = id_len;
            HDR_POS_CMAP_TYPE: hb = cmap_type;
            HDR_POS_IMG_TYPE:  hb = img_type;
            HDR_POS_WIDTH_LO:  hb = w[7:0];
            HDR_POS_WIDTH_HI:  hb = w[15:8];
            HDR_POS_HEIGHT_LO: hb = h[7:0];
            HDR_POS_HEIGHT_HI: hb = h[15:8];
            HDR_POS_DEPTH:     hb = depth;
            default:           hb = 8'($urandom);
         endcase
         push_item(hb, pos == 0);
      end
      total = 32'(w) * 32'(h);
      if (cmap_type != 8'd0 || (img_type != IMG_TYPE_RAW && img_type != IMG_TYPE_RLE) ||
          (depth != DEPTH_24 && depth != DEPTH_32) || total == 0)
         return;
      body_left = budget;
      bpp = (depth == DEPTH_32) ? 4 : 3;
      for (int i = 0; i < id_len; i++) push_body(8'($urandom));
      remaining = total;
      while (remaining > 0 && body_left > 0) begin
         if (img_type == IMG_TYPE_RAW) begin
            for (int c = 0; c < bpp; c++) push_body(pick_byte(fill));
            remaining--;
         end else begin
            case (style)
               PKT_LONG_RUNS: begin len = 128; run = 1'b1; end
               PKT_LONG_RAW:  begin len = 128; run = 1'b0; end
               default: begin
                  len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128)
                                                    : $urandom_range(1, 4);
                  run = 1'($urandom_range(0, 1));
               end
            endcase
            // Raw packets rarely spill past the image end; those bytes are ignored.
            if (!run && len > remaining) len = remaining + $urandom_range(0, 1);
            if (len > 128) len = 128;
            push_body({run, 7'(len - 1)});
            if (run) begin
               for (int c = 0; c < bpp; c++) push_body(pick_byte(fill));
            end else begin
               for (int p = 0; p < len; p++)
                  for (int c = 0; c < bpp; c++) push_body(pick_byte(fill));
            end
            remaining = (len > remaining) ? 0 : remaining - len;
         end
      end
   endtask

   // One random file, mostly well formed, some truncated, broken or pure noise.
   task random_file();
      int          start_count;
      int          pick;
      logic [7:0]  t;
      logic [7:0]  d;
      logic [7:0]  idl;
      logic [15:0] w;
      logic [15:0] h;
      start_count = bytes_queued;
      pick = $urandom_range(0, 99);
      t = $urandom_range(0, 1) ? IMG_TYPE_RLE : IMG_TYPE_RAW;
      d = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
      if (t == IMG_TYPE_RLE && $urandom_range(0, 4) == 0) begin
         w = 16'($urandom_range(1, 300));
         h = 16'd1;
      end else begin
         w = 16'($urandom_range(1, 6));
         h = 16'($urandom_range(1, 6));
      end
      idl = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 4)) : 8'd0;
      if (pick < 70) begin
         emit_file(t, 8'd0, d, w, h, idl, -1, PKT_MIXED, WHOLE_FILE);
      end else if (pick < 80) begin
         if ($urandom_range(0, 3) == 0) begin
            w = 16'($urandom);
            h = 16'($urandom);
         end
         emit_file(t, 8'd0, d, w, h, idl, -1, PKT_MIXED, $urandom_range(0, 24));
      end else if (pick < 88) begin
         emit_file(($urandom_range(0, 2) == 0) ? 8'($urandom) : t,
                   ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'd0,
                   ($urandom_range(0, 1) == 0) ? 8'($urandom) : d,
                   w, h, idl, -1, PKT_MIXED, WHOLE_FILE);
      end else if (pick < 93) begin
         if ($urandom_range(0, 1)) w = 16'd0;
         else h = 16'd0;
         if ($urandom_range(0, 3) == 0) begin
            w = 16'd0;
            h = 16'd0;
         end
         emit_file(t, 8'd0, d, w, h, idl, -1, PKT_MIXED, WHOLE_FILE);
      end else if (pick < 97) begin
         push_item(8'($urandom), 1'b1);
         repeat ($urandom_range(0, 16)) push_item(8'($urandom), 1'b0);
      end else begin
         repeat ($urandom_range(1, 12)) push_item(8'($urandom), $urandom_range(0, 7) == 0);
      end
      file_bytes += bytes_queued - start_count;
      // Trailing bytes with no new file marker, ignored once the image has ended.
      repeat ($urandom_range(0, 2)) push_item(8'($urandom), 1'b0);
   endtask

   task write_alpha_mode(input logic v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_invert_alpha <= v;
      do @(posedge clock); while (!csr_ready);
      cfg_invert = v;
      csr_valid <= 1'b0;
   endtask

   // Wait until every byte is taken and every predicted item has arrived.
   task drain();
      while (!(bytes_accepted == bytes_queued && predicted_records.size() == 0))
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tga_rle_pixel_decoder regression: fail");
      $finish;
   end

   initial begin : main
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_alpha_mode(1'b0);

      // Directed files: pixel extremes, alpha handling, clipping, empty and bad headers.
      push_item(8'hA5, 1'b0);
      push_item(8'h5A, 1'b0);
      emit_file(IMG_TYPE_RAW, 8'd0, DEPTH_24, 16'd2, 16'd1, 8'd0, 0, PKT_MIXED, WHOLE_FILE);
      emit_file(IMG_TYPE_RAW, 8'd0, DEPTH_32, 16'd1, 16'd2, 8'd3, 255, PKT_MIXED,
                WHOLE_FILE);
      emit_file(IMG_TYPE_RAW, 8'd0, DEPTH_32, 16'd1, 16'd1, 8'd0, 0, PKT_MIXED, WHOLE_FILE);
      emit_file(IMG_TYPE_RLE, 8'd0, DEPTH_32, 16'd130, 16'd1, 8'd0, -1, PKT_LONG_RUNS,
                WHOLE_FILE);
      push_item(8'h3C, 1'b0);
      emit_file(IMG_TYPE_RLE, 8'd0, DEPTH_24, 16'd3, 16'd2, 8'd1, -1, PKT_LONG_RAW,
                WHOLE_FILE);
      emit_file(IMG_TYPE_RAW, 8'd0, DEPTH_24, 16'd0, 16'd5, 8'd0, -1, PKT_MIXED, WHOLE_FILE);
      emit_file(IMG_TYPE_RLE, 8'd0, DEPTH_32, 16'd7, 16'd0, 8'd2, -1, PKT_MIXED, WHOLE_FILE);
      emit_file(8'd3, 8'd0, DEPTH_24, 16'd1, 16'd1, 8'd0, -1, PKT_MIXED, WHOLE_FILE);
      emit_file(IMG_TYPE_RAW, 8'd1, DEPTH_24, 16'd1, 16'd1, 8'd0, -1, PKT_MIXED, WHOLE_FILE);
      emit_file(IMG_TYPE_RAW, 8'd0, 8'd16, 16'd1, 16'd1, 8'd0, -1, PKT_MIXED, WHOLE_FILE);
      emit_file(8'd0, 8'd1, DEPTH_24, 16'd1, 16'd1, 8'd0, -1, PKT_MIXED, WHOLE_FILE);
      emit_file(IMG_TYPE_RLE, 8'd255, 8'd8, 16'd1, 16'd1, 8'd0, -1, PKT_MIXED, WHOLE_FILE);
      emit_file(IMG_TYPE_RLE, 8'd0, DEPTH_32, 16'hFFFF, 16'hFFFF, 8'd0, -1, PKT_LONG_RUNS,
                12);
      push_item(8'd0, 1'b1);
      repeat (4) push_item(8'd0, 1'b0);
      emit_file(IMG_TYPE_RAW, 8'd0, DEPTH_24, 16'd1, 16'd1, 8'd255, -1, PKT_MIXED,
                WHOLE_FILE);
      emit_file(IMG_TYPE_RAW, 8'd0, DEPTH_24, 16'd2, 16'd2, 8'd10, -1, PKT_MIXED, 4);
      emit_file(IMG_TYPE_RLE, 8'd0, DEPTH_24, 16'd2, 16'd2, 8'd0, -1, PKT_MIXED, WHOLE_FILE);
      drain();

      // Random files in four stretches, alternating the alpha mode and varying the pacing.
      for (int ph = 0; ph < 4; ph++) begin
         write_alpha_mode(ph % 2 == 0);
         pace_gaps <= (ph != 2) && (ph != 3);
         pace_stalls <= (ph != 2);
         while (file_bytes < RANDOM_BYTES * (ph + 1) / 4) random_file();
         drain();
      end

      if (fail_count == 0 && predicted_records.size() == 0) begin
         $display("tga_rle_pixel_decoder regression: pass");
      end else begin
         $display("tga_rle_pixel_decoder regression: fail");
      end
      $finish;
   end

endmodule
